[design/bmp24_pkg.sv]
// bmp24_pkg: shared types, constants and the header byte table of the bmp24 encoder
// no dependencies; compiled first

package bmp24_pkg;

   // dimension and size widths
   localparam int DIM_BITS       = 14;
   localparam int ROW_BYTES_BITS = DIM_BITS + 2;
   localparam int SIZE_BITS      = 32;
   localparam int HDR_BYTES      = 54;
   localparam int HDR_IDX_BITS   = 6;
   localparam int PAD_BITS       = 2;

   // configuration register indexes
   localparam int CSR_INDEX_BITS = 1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_IMAGE_WIDTH  = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_IMAGE_HEIGHT = 1'b1;

   // fixed header values
   localparam logic [7:0] BMP_SIG_B      = 8'h42;
   localparam logic [7:0] BMP_SIG_M      = 8'h4D;
   localparam logic [7:0] PIXEL_OFFSET   = 8'h36;
   localparam logic [7:0] INFO_SIZE      = 8'h28;
   localparam logic [7:0] PLANE_COUNT    = 8'h01;
   localparam logic [7:0] BITS_PER_PIXEL = 8'h18;

   // header byte offsets
   localparam logic [HDR_IDX_BITS-1:0] OFS_SIG    = 6'd0;
   localparam logic [HDR_IDX_BITS-1:0] OFS_SIZE   = 6'd2;
   localparam logic [HDR_IDX_BITS-1:0] OFS_DATA   = 6'd10;
   localparam logic [HDR_IDX_BITS-1:0] OFS_INFO   = 6'd14;
   localparam logic [HDR_IDX_BITS-1:0] OFS_WIDTH  = 6'd18;
   localparam logic [HDR_IDX_BITS-1:0] OFS_HEIGHT = 6'd22;
   localparam logic [HDR_IDX_BITS-1:0] OFS_PLANES = 6'd26;
   localparam logic [HDR_IDX_BITS-1:0] OFS_BPP    = 6'd28;
   localparam logic [HDR_IDX_BITS-1:0] HDR_LAST   = 6'd53;

   // effective image dimensions (zero already mapped to one)
   typedef struct packed {
      logic [DIM_BITS-1:0] width;
      logic [DIM_BITS-1:0] height;
   } dims_type;

   // one classified pixel waiting for the byte sequencer
   typedef struct packed {
      logic [7:0]          red;
      logic [7:0]          green;
      logic [7:0]          blue;
      logic                need_header;
      logic                img_end;
      logic [PAD_BITS-1:0] pad;
   } queue_entry_type;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_HEADER,
      PH_BLUE,
      PH_GREEN,
      PH_RED,
      PH_PAD
   } phase_type;

   // byte of the 54-byte file and info header at a given offset
   function automatic logic [7:0] hdr_byte(input logic [HDR_IDX_BITS-1:0] idx,
                                           input logic [SIZE_BITS-1:0]    size,
                                           input logic [DIM_BITS-1:0]     w,
                                           input logic [DIM_BITS-1:0]     h);
      logic [31:0] w32;
      logic [31:0] negh;
      logic [7:0]  b;
      w32  = {{(32-DIM_BITS){1'b0}}, w};
      negh = 32'd0 - {{(32-DIM_BITS){1'b0}}, h};
      unique case (idx)
         OFS_SIG:          b = BMP_SIG_B;
         OFS_SIG + 6'd1:   b = BMP_SIG_M;
         OFS_SIZE:         b = size[7:0];
         OFS_SIZE + 6'd1:  b = size[15:8];
         OFS_SIZE + 6'd2:  b = size[23:16];
         OFS_SIZE + 6'd3:  b = size[31:24];
         OFS_DATA:         b = PIXEL_OFFSET;
         OFS_INFO:         b = INFO_SIZE;
         OFS_WIDTH:        b = w32[7:0];
         OFS_WIDTH + 6'd1: b = w32[15:8];
         OFS_WIDTH + 6'd2: b = w32[23:16];
         OFS_WIDTH + 6'd3: b = w32[31:24];
         OFS_HEIGHT:       b = negh[7:0];
         OFS_HEIGHT + 6'd1: b = negh[15:8];
         OFS_HEIGHT + 6'd2: b = negh[23:16];
         OFS_HEIGHT + 6'd3: b = negh[31:24];
         OFS_PLANES:       b = PLANE_COUNT;
         OFS_BPP:          b = BITS_PER_PIXEL;
         default:          b = 8'h00;
      endcase
      return b;
   endfunction

endpackage

[design/bmp24_pix_if.sv]
// bmp24_pix_if: pixel channel (valid, ready, red, green, blue)
// no dependencies

interface bmp24_pix_if;
   logic       valid;
   logic       ready;
   logic [7:0] red;
   logic [7:0] green;
   logic [7:0] blue;

   modport source (output valid, red, green, blue, input ready);
   modport sink   (input valid, red, green, blue, output ready);
endinterface

[design/bmp24_byte_if.sv]
// bmp24_byte_if: byte stream channel (valid, ready, out_byte and flags)
// no dependencies

interface bmp24_byte_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       last_of_run;
   logic       end_of_image;

   modport source (output valid, out_byte, last_of_run, end_of_image, input ready);
   modport sink   (input valid, out_byte, last_of_run, end_of_image, output ready);
endinterface

[design/bmp24_csr_if.sv]
// bmp24_csr_if: register write channel (valid, ready, index, data)
// depends on bmp24_pkg for widths

interface bmp24_csr_if;
   import bmp24_pkg::*;
   logic                      valid;
   logic                      ready;
   logic [CSR_INDEX_BITS-1:0] index;
   logic [DIM_BITS-1:0]       data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

[design/bmp24_front.sv]
// bmp24_front: accepts pixels, tracks row and column, classifies header/padding/end
// depends on bmp24_pkg and bmp24_pix_if

module bmp24_front (
   input  logic                       clock,
   input  logic                       reset,
   bmp24_pix_if.sink                  req_if,
   input  bmp24_pkg::dims_type        dims,
   output bmp24_pkg::queue_entry_type push_entry,
   output logic                       push_valid,
   input  logic                       push_ready
);
   import bmp24_pkg::*;

   logic                header_sent_ff, header_sent_in;
   logic [DIM_BITS-1:0] column_ff, column_in;
   logic [DIM_BITS-1:0] row_ff, row_in;
   logic [DIM_BITS:0]   column_next;
   logic [DIM_BITS:0]   row_next;
   logic                row_end;
   logic                img_end;
   logic                accept;

   // handshake straight onto the queue
   assign req_if.ready = push_ready;
   assign push_valid   = req_if.valid;
   assign accept       = req_if.valid && push_ready;

   // position classification
   assign column_next = {1'b0, column_ff} + {{DIM_BITS{1'b0}}, 1'b1};
   assign row_next    = {1'b0, row_ff} + {{DIM_BITS{1'b0}}, 1'b1};
   assign row_end     = column_next >= {1'b0, dims.width};
   assign img_end     = row_end && (row_next >= {1'b0, dims.height});

   // queue entry; padding length is the low two bits of the width
   always_comb begin
      push_entry.red         = req_if.red;
      push_entry.green       = req_if.green;
      push_entry.blue        = req_if.blue;
      push_entry.need_header = !header_sent_ff;
      push_entry.img_end     = img_end;
      push_entry.pad         = row_end ? dims.width[PAD_BITS-1:0] : '0;
   end

   // position state update
   always_comb begin
      header_sent_in = header_sent_ff;
      column_in      = column_ff;
      row_in         = row_ff;
      if (accept) begin
         header_sent_in = 1'b1;
         if (row_end) begin
            column_in = '0;
            if (img_end) begin
               row_in         = '0;
               header_sent_in = 1'b0;
            end else begin
               row_in = row_next[DIM_BITS-1:0];
            end
         end else begin
            column_in = column_next[DIM_BITS-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         header_sent_ff <= 1'b0;
         column_ff      <= '0;
         row_ff         <= '0;
      end else begin
         header_sent_ff <= header_sent_in;
         column_ff      <= column_in;
         row_ff         <= row_in;
      end
   end

endmodule

[design/bmp24_queue.sv]
// bmp24_queue: short flip-flop queue of classified pixels between front and back
// depends on bmp24_pkg

module bmp24_queue #(
   parameter int DEPTH = 4
) (
   input  logic                       clock,
   input  logic                       reset,
   input  bmp24_pkg::queue_entry_type push_entry,
   input  logic                       push_valid,
   output logic                       push_ready,
   output bmp24_pkg::queue_entry_type pop_entry,
   output logic                       pop_valid,
   input  logic                       pop_ready
);
   import bmp24_pkg::*;

   localparam int PTR_BITS   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int COUNT_BITS = $clog2(DEPTH + 1);

   queue_entry_type       entries_ff [DEPTH];
   logic [PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic                  do_push;
   logic                  do_pop;

   assign push_ready = count_ff != COUNT_BITS'(DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_entry  = entries_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

[design/bmp24_back.sv]
// bmp24_back: byte sequencer; expands queued pixels into header, BGR and padding bytes
// depends on bmp24_pkg and bmp24_byte_if

module bmp24_back (
   input  logic                       clock,
   input  logic                       reset,
   input  bmp24_pkg::dims_type        dims,
   input  bmp24_pkg::queue_entry_type pop_entry,
   input  logic                       pop_valid,
   output logic                       pop_ready,
   bmp24_byte_if.source               rsp_if
);
   import bmp24_pkg::*;

   localparam int PROD_BITS = ROW_BYTES_BITS + DIM_BITS;

   phase_type                 phase_ff, phase_in;
   queue_entry_type           cur_ff, cur_in;
   logic [HDR_IDX_BITS-1:0]   hdr_idx_ff, hdr_idx_in;
   logic [PAD_BITS-1:0]       pad_left_ff, pad_left_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [7:0]                rsp_byte_ff;
   logic                      rsp_last_ff;
   logic                      rsp_eoi_ff;
   logic [ROW_BYTES_BITS-1:0] row_bytes_ff, row_bytes_in;
   logic [SIZE_BITS-1:0]      size_ff, size_in;
   logic [PROD_BITS-1:0]      size_prod;
   logic                      out_free;
   logic                      emit;
   logic                      finish;
   logic [7:0]                e_byte;
   logic                      e_last;
   logic                      e_eoi;

   // file size: row bytes first, then one multiply
   assign row_bytes_in = ({{2{1'b0}}, dims.width} << 1) + {{2{1'b0}}, dims.width}
                         + {{(ROW_BYTES_BITS-PAD_BITS){1'b0}}, dims.width[PAD_BITS-1:0]};
   assign size_prod    = row_bytes_ff * dims.height;
   assign size_in      = SIZE_BITS'(size_prod) + SIZE_BITS'(HDR_BYTES);

   always_ff @(posedge clock) begin
      row_bytes_ff <= row_bytes_in;
      size_ff      <= size_in;
   end

   assign out_free = !rsp_valid_ff || rsp_if.ready;

   // sequencer next state
   always_comb begin
      phase_in    = phase_ff;
      cur_in      = cur_ff;
      hdr_idx_in  = hdr_idx_ff;
      pad_left_in = pad_left_ff;
      pop_ready   = 1'b0;
      emit        = 1'b0;
      finish      = 1'b0;
      e_byte      = 8'h00;
      e_last      = 1'b0;
      e_eoi       = 1'b0;
      unique case (phase_ff)
         PH_IDLE: begin
            if (pop_valid) begin
               pop_ready  = 1'b1;
               cur_in     = pop_entry;
               hdr_idx_in = '0;
               phase_in   = pop_entry.need_header ? PH_HEADER : PH_BLUE;
            end
         end
         PH_HEADER: begin
            if (out_free) begin
               emit   = 1'b1;
               e_byte = hdr_byte(hdr_idx_ff, size_ff, dims.width, dims.height);
               if (hdr_idx_ff == HDR_LAST) begin
                  hdr_idx_in = '0;
                  phase_in   = PH_BLUE;
               end else begin
                  hdr_idx_in = hdr_idx_ff + 1'b1;
               end
            end
         end
         PH_BLUE: begin
            if (out_free) begin
               emit     = 1'b1;
               e_byte   = cur_ff.blue;
               phase_in = PH_GREEN;
            end
         end
         PH_GREEN: begin
            if (out_free) begin
               emit     = 1'b1;
               e_byte   = cur_ff.green;
               phase_in = PH_RED;
            end
         end
         PH_RED: begin
            if (out_free) begin
               emit   = 1'b1;
               e_byte = cur_ff.red;
               if (cur_ff.pad == '0) begin
                  e_last = 1'b1;
                  e_eoi  = cur_ff.img_end;
                  finish = 1'b1;
               end else begin
                  pad_left_in = cur_ff.pad;
                  phase_in    = PH_PAD;
               end
            end
         end
         PH_PAD: begin
            if (out_free) begin
               emit   = 1'b1;
               e_byte = 8'h00;
               if (pad_left_ff == PAD_BITS'(1)) begin
                  e_last = 1'b1;
                  e_eoi  = cur_ff.img_end;
                  finish = 1'b1;
               end else begin
                  pad_left_in = pad_left_ff - 1'b1;
               end
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
      // chain straight into the next queued pixel
      if (finish) begin
         if (pop_valid) begin
            pop_ready  = 1'b1;
            cur_in     = pop_entry;
            hdr_idx_in = '0;
            phase_in   = pop_entry.need_header ? PH_HEADER : PH_BLUE;
         end else begin
            phase_in = PH_IDLE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_IDLE;
         hdr_idx_ff  <= '0;
         pad_left_ff <= '0;
      end else begin
         phase_ff    <= phase_in;
         hdr_idx_ff  <= hdr_idx_in;
         pad_left_ff <= pad_left_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_byte_ff <= e_byte;
         rsp_last_ff <= e_last;
         rsp_eoi_ff  <= e_eoi;
      end
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.out_byte     = rsp_byte_ff;
   assign rsp_if.last_of_run  = rsp_last_ff;
   assign rsp_if.end_of_image = rsp_eoi_ff;

endmodule

[design/bmp24_stream_encoder_top.sv]
// bmp24_stream_encoder_top: 24-bit BMP byte stream encoder, top level
// depends on bmp24_pkg, the three channel interfaces, bmp24_front, bmp24_queue, bmp24_back
//
// channel   direction  transaction
// req_if    in         one pixel: red, green, blue
// rsp_if    out        one file byte: out_byte, last_of_run, end_of_image
// csr_if    in         register write: index, data (always ready)
//
// each pixel gives three bytes at one byte per cycle, while the output is not stalled,
// through the output register; the first pixel of an image adds 54 header bytes and
// a row-ending pixel adds 0 to 3 padding bytes. the byte sequencer sets the rate.
// the pixel queue lets the input run ahead while the output is stalled.
// reset is synchronous; both dimension registers reset to 1, no clearing pass.

module bmp24_stream_encoder_top #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic          clock,
   input  logic          reset,
   bmp24_pix_if.sink     req_if,
   bmp24_byte_if.source  rsp_if,
   bmp24_csr_if.sink     csr_if
);
   import bmp24_pkg::*;

   logic [DIM_BITS-1:0] width_ff, width_in;
   logic [DIM_BITS-1:0] height_ff, height_in;
   dims_type            dims;
   queue_entry_type     push_entry;
   logic                push_valid;
   logic                push_ready;
   queue_entry_type     pop_entry;
   logic                pop_valid;
   logic                pop_ready;

   // dimension registers
   assign csr_if.ready = 1'b1;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_if.valid) begin
         unique case (csr_if.index)
            CSR_IMAGE_WIDTH:  width_in  = csr_if.data;
            CSR_IMAGE_HEIGHT: height_in = csr_if.data;
            default: begin
               width_in  = width_ff;
               height_in = height_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= DIM_BITS'(1);
         height_ff <= DIM_BITS'(1);
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   // a zero dimension acts as one
   assign dims.width  = (width_ff == '0) ? DIM_BITS'(1) : width_ff;
   assign dims.height = (height_ff == '0) ? DIM_BITS'(1) : height_ff;

   bmp24_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_if     (req_if),
      .dims       (dims),
      .push_entry (push_entry),
      .push_valid (push_valid),
      .push_ready (push_ready)
   );

   bmp24_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_entry (push_entry),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .pop_entry  (pop_entry),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready)
   );

   bmp24_back u_back (
      .clock     (clock),
      .reset     (reset),
      .dims      (dims),
      .pop_entry (pop_entry),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .rsp_if    (rsp_if)
   );

endmodule
